### rtl/integer_to_ascii_radix_formatter_assert.svh
// Assertion macros for the integer to ASCII radix formatter.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2A_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/i2a_pkg.sv
package i2a_pkg;

	// Radix kinds; any other code formats as decimal.
	localparam logic [1:0] KIND_BIN = 2'd1;
	localparam logic [1:0] KIND_HEX = 2'd2;

	// Digit register: ten BCD digits, or a left-aligned magnitude.
	localparam int WORK_W = 40;
	localparam int MAG_W  = 32;
	localparam int CNT_W  = 6;

	localparam logic [CNT_W-1:0] DAB_ITER   = 6'd32;
	localparam logic [CNT_W-1:0] BIN_DIGITS = 6'd32;
	localparam logic [CNT_W-1:0] HEX_DIGITS = 6'd8;
	localparam logic [CNT_W-1:0] DEC_DIGITS = 6'd10;

	// ASCII codes.
	localparam logic [6:0] CH_MINUS    = 7'h2D;
	localparam logic [6:0] CH_ZERO     = 7'h30;
	localparam logic [6:0] CH_B        = 7'h62;
	localparam logic [6:0] CH_X        = 7'h78;
	localparam logic [6:0] CH_HEX_BASE = 7'h57;
	localparam logic [3:0] MAX_DEC_DIG = 4'd9;

	typedef enum logic [1:0] {
		SEL_MINUS,
		SEL_ZERO,
		SEL_PFX,
		SEL_DIGIT
	} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      dabble;
		logic      shift;
		logic      emit;
		char_sel_t sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_dec;
		logic neg;
		logic has_pfx;
		logic cnt_one;
		logic top_zero;
		logic dab_done;
	} dp_stat_t;

endpackage

### rtl/i2a_ctrl.sv
module i2a_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  i2a_pkg::dp_stat_t   stat,
	output i2a_pkg::ctrl_cmd_t  cmd
);
	import i2a_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CONV  = 7'b0000010,
		S_SKIP  = 7'b0000100,
		S_SIGN  = 7'b0001000,
		S_PFX0  = 7'b0010000,
		S_PFXC  = 7'b0100000,
		S_DIGIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   can_emit;

	assign can_emit  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.dabble = 1'b0;
		cmd.shift  = 1'b0;
		cmd.emit   = 1'b0;
		cmd.sel    = SEL_DIGIT;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				if (stat.is_dec && !stat.dab_done) begin
					cmd.dabble = 1'b1;
				end else begin
					state_d = S_SKIP;
				end
			end
			S_SKIP: begin
				if (!stat.cnt_one && stat.top_zero) begin
					cmd.shift = 1'b1;
				end else if (stat.neg) begin
					state_d = S_SIGN;
				end else if (stat.has_pfx) begin
					state_d = S_PFX0;
				end else begin
					state_d = S_DIGIT;
				end
			end
			S_SIGN: begin
				cmd.sel = SEL_MINUS;
				if (can_emit) begin
					cmd.emit = 1'b1;
					state_d  = stat.has_pfx ? S_PFX0 : S_DIGIT;
				end
			end
			S_PFX0: begin
				cmd.sel = SEL_ZERO;
				if (can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_PFXC;
				end
			end
			S_PFXC: begin
				cmd.sel = SEL_PFX;
				if (can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (can_emit) begin
					cmd.emit  = 1'b1;
					cmd.shift = 1'b1;
					if (stat.cnt_one) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/i2a_dp.sv
module i2a_dp (
	input  logic                clk,
	input  logic [1:0]          kind,
	input  logic [31:0]         value,
	input  i2a_pkg::ctrl_cmd_t  cmd,
	output i2a_pkg::dp_stat_t   stat,
	output logic [6:0]          char_out,
	output logic                last
);
	import i2a_pkg::*;

	logic [1:0]        kind_q;
	logic              neg_q;
	logic [WORK_W-1:0] work_q;
	logic [MAG_W-1:0]  bin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  dab_q;
	logic [6:0]        char_q;
	logic              last_q;

	logic              kind_bin, kind_hex, kind_dec;
	logic              load_bin, load_hex;
	logic [MAG_W-1:0]  mag;
	logic [WORK_W-1:0] adj;
	logic [3:0]        top_digit;
	logic [6:0]        digit_char;
	logic [6:0]        char_d;

	assign kind_bin = (kind_q == KIND_BIN);
	assign kind_hex = (kind_q == KIND_HEX);
	assign kind_dec = !kind_bin && !kind_hex;
	assign load_bin = (kind == KIND_BIN);
	assign load_hex = (kind == KIND_HEX);

	assign mag = value[MAG_W-1] ? (~value + 32'd1) : value;

	// Add-3 correction on every BCD digit before the shift.
	always_comb begin
		for (int i = 0; i < WORK_W / 4; i++) begin
			adj[i*4 +: 4] = (work_q[i*4 +: 4] > 4'd4) ? (work_q[i*4 +: 4] + 4'd3)
				: work_q[i*4 +: 4];
		end
	end

	assign top_digit  = kind_bin ? {3'b000, work_q[WORK_W-1]} : work_q[WORK_W-1 -: 4];
	assign digit_char = (top_digit > MAX_DEC_DIG) ? (CH_HEX_BASE + {3'b000, top_digit})
		: (CH_ZERO + {3'b000, top_digit});

	always_comb begin
		case (cmd.sel)
			SEL_MINUS: char_d = CH_MINUS;
			SEL_ZERO:  char_d = CH_ZERO;
			SEL_PFX:   char_d = kind_bin ? CH_B : CH_X;
			SEL_DIGIT: char_d = digit_char;
			default:   char_d = digit_char;
		endcase
	end

	assign stat.is_dec   = kind_dec;
	assign stat.neg      = neg_q;
	assign stat.has_pfx  = !kind_dec;
	assign stat.cnt_one  = (cnt_q == 6'd1);
	assign stat.top_zero = (top_digit == 4'd0);
	assign stat.dab_done = (dab_q == 6'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			neg_q  <= value[MAG_W-1];
			bin_q  <= mag;
			dab_q  <= DAB_ITER;
			if (load_bin) begin
				work_q <= {mag, 8'h00};
				cnt_q  <= BIN_DIGITS;
			end else if (load_hex) begin
				work_q <= {mag, 8'h00};
				cnt_q  <= HEX_DIGITS;
			end else begin
				work_q <= '0;
				cnt_q  <= DEC_DIGITS;
			end
		end else if (cmd.dabble) begin
			work_q <= {adj[WORK_W-2:0], bin_q[MAG_W-1]};
			bin_q  <= {bin_q[MAG_W-2:0], 1'b0};
			dab_q  <= dab_q - 6'd1;
		end else if (cmd.shift) begin
			work_q <= kind_bin ? {work_q[WORK_W-2:0], 1'b0} : {work_q[WORK_W-5:0], 4'h0};
			cnt_q  <= cnt_q - 6'd1;
		end
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= (cmd.sel == SEL_DIGIT) && (cnt_q == 6'd1);
		end
	end

	assign char_out = char_q;
	assign last     = last_q;

endmodule

### rtl/integer_to_ascii_radix_formatter.sv
// Order: binary and hex are loaded and then skip leading zero digits before the first
// character; decimal adds the shift-add-3 conversion. Characters then leave one per cycle
// while out_ready stays high. Throughput: one number at a time; the next number is taken
// only after the last digit of the previous one is loaded into the output register.
// Reset: arst_n clears the controller state and the output valid flag asynchronously.
`include "integer_to_ascii_radix_formatter_assert.svh"

module integer_to_ascii_radix_formatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         char_out,
	output logic               last
);
	import i2a_pkg::*;

	// The controller sequences one number through four phases. After the input beat
	// is taken, a decimal number is converted to ten BCD digits by the shift-add-3
	// method, one magnitude bit per cycle. Binary and hex need no conversion, since
	// their digits are bit fields of the magnitude, which is stored left-aligned.
	// The skip phase then drops leading zero digits one per cycle, always keeping at
	// least one digit so that zero prints as a single '0'. Finally the sign, the
	// prefix and the digits leave through a single output register, one beat per
	// character, with last marking the final digit.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	i2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the magnitude, the digit register, the digit count and the
	// output register; it acts only on the controller's commands.
	i2a_dp u_dp (
		.clk      (clk),
		.kind     (kind),
		.value    (value),
		.cmd      (cmd),
		.stat     (stat),
		.char_out (char_out),
		.last     (last)
	);

	// Only one number is in flight: after an input beat the block is busy.
	`I2A_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
	// When the block is ready for a new number, any beat still waiting is the last one.
	`I2A_ASSERT_SAME(a_idle_only_last, in_ready && out_valid, last, "idle with unfinished number")
	// A minus sign or the hex prefix letter x never ends a number.
	`I2A_ASSERT_SAME(a_no_last_on_sign, out_valid && (char_out == CH_MINUS || char_out == CH_X),
		!last, "number ends without digits")

endmodule

### test/integer_to_ascii_radix_formatter_tb.sv
`timescale 1ns / 100ps

// Testbench for the integer to ASCII radix formatter.
// Every number handed to the block is run through a local predictor that
// builds the expected character string. The checker pops one expected
// character per output beat and compares both the character and the last flag.
module integer_to_ascii_radix_formatter_tb;
	import i2a_pkg::*;

	// The package names only binary and hex. Every other code prints as decimal.
	localparam logic [1:0] KIND_DEC   = 2'd0;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 80;
	localparam int RANDOM_ITEMS   = 400;
	localparam int CLEAN_ITEMS    = 40;

	// One output beat: a character and its end-of-number flag.
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} char_beat_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [6:0]         char_out;
	logic               last;

	char_beat_t expected_chars[$];
	int         error_count;
	int         idle_cycles;
	bit         send_idle_en;
	bit         recv_idle_en;
	bit         hold_req;

	integer_to_ascii_radix_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.last      (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	// Builds the text of one number and queues it as expected beats.
	// A negative value starts with a minus sign, then comes the prefix of the
	// radix, then the digits of the magnitude, most significant first.
	// The magnitude is taken unsigned, so the most negative value works out
	// to two to the 31st without overflow.
	task automatic predict_text(input logic [1:0] k, input logic signed [31:0] v);
		logic [31:0] mag;
		logic [31:0] radix;
		logic [6:0]  pfx_ch;
		logic [3:0]  digits[$];
		logic [6:0]  text[$];
		char_beat_t  beat;
		bit          has_pfx;

		mag     = v[31] ? (32'd0 - v) : v;
		radix   = 32'd10;
		has_pfx = 1'b0;
		pfx_ch  = CH_ZERO;
		if (k == KIND_BIN) begin
			radix   = 32'd2;
			has_pfx = 1'b1;
			pfx_ch  = CH_B;
		end else if (k == KIND_HEX) begin
			radix   = 32'd16;
			has_pfx = 1'b1;
			pfx_ch  = CH_X;
		end

		// Digits come out least significant first. Zero still yields one digit.
		do begin
			digits.push_front(4'(mag % radix));
			mag = mag / radix;
		end while (mag != 32'd0);

		if (v[31]) begin
			text.push_back(CH_MINUS);
		end
		if (has_pfx) begin
			text.push_back(CH_ZERO);
			text.push_back(pfx_ch);
		end
		foreach (digits[i]) begin
			if (digits[i] > MAX_DEC_DIG) begin
				text.push_back(CH_HEX_BASE + 7'(digits[i]));
			end else begin
				text.push_back(CH_ZERO + 7'(digits[i]));
			end
		end

		foreach (text[i]) begin
			beat.ch   = text[i];
			beat.last = (i == text.size() - 1);
			expected_chars.push_back(beat);
		end
	endtask

	// Input monitor and output checker share one process, so a number is
	// always predicted before any character it can cause is checked.
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_text(kind, value);
			end
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h last %0b",
						char_out, last));
				end else begin
					want = expected_chars.pop_front();
					if (char_out !== want.ch) begin
						report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
							char_out, want.ch));
					end
					if (last !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
							last, want.last, want.ch));
					end
				end
			end
		end
	end

	// Receiver side. It normally accepts every beat, stalls in short random
	// bursts while idling is enabled, and on request holds off for a long
	// stretch so the block backs up and stops taking new numbers.
	// At most one assignment to out_ready happens at each falling edge.
	initial begin : receiver
		int gap;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 3);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Ends the run if nothing moves on either channel for too long.
	// The limit covers the long receiver hold plus the slowest decimal number.
	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offers one number and returns right after the edge that takes it.
	// Valid stays high into the next call unless a random gap is inserted,
	// so back-to-back beats never lower and raise valid in one step.
	task automatic send_number(input logic [1:0] k, input logic signed [31:0] v);
		int gap;
		@(negedge clk);
		if (send_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Waits until every predicted character has been seen on the output.
	task automatic wait_for_drain();
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	// Radix kind with the unused code showing up now and then.
	function automatic logic [1:0] random_kind();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 9) begin
			return KIND_SPARE;
		end
		return (pick % 3 == 0) ? KIND_DEC : ((pick % 3 == 1) ? KIND_BIN : KIND_HEX);
	endfunction

	// Value mix: raw words, small numbers of either sign, powers of two and
	// their neighbors, the extremes, and arithmetic shifts that spread the
	// magnitude over every digit count.
	function automatic logic signed [31:0] random_value();
		logic [31:0] raw;
		logic [31:0] pow;
		raw = $urandom;
		pow = 32'd1 << $urandom_range(0, 31);
		case ($urandom_range(0, 5))
			0: return raw;
			1: return raw[0] ? -$signed($urandom_range(0, 300)) : $urandom_range(0, 300);
			2: return pow - 32'($urandom_range(0, 2)) + 32'd1;
			3: return raw[0] ? 32'h8000_0000 + 32'(raw[3:1]) : 32'h7fff_ffff - 32'(raw[3:1]);
			default: return $signed(raw) >>> $urandom_range(0, 31);
		endcase
	endfunction

	// Zero and the most negative value in every radix kind including the unused
	// code, then the largest value, digit roll-over points and every hex letter.
	task automatic test_directed();
		send_number(KIND_DEC, 32'sd0);
		send_number(KIND_BIN, 32'sd0);
		send_number(KIND_HEX, 32'sd0);
		send_number(KIND_SPARE, 32'sd0);
		send_number(KIND_DEC, 32'h8000_0000);
		send_number(KIND_BIN, 32'h8000_0000);
		send_number(KIND_HEX, 32'h8000_0000);
		send_number(KIND_SPARE, 32'h8000_0000);
		send_number(KIND_DEC, 32'h7fff_ffff);
		send_number(KIND_BIN, 32'h7fff_ffff);
		send_number(KIND_HEX, 32'h7fff_ffff);
		send_number(KIND_DEC, -32'sd1);
		send_number(KIND_BIN, -32'sd1);
		send_number(KIND_HEX, -32'sd1);
		send_number(KIND_SPARE, -32'sd10);
		send_number(KIND_DEC, 32'sd9);
		send_number(KIND_DEC, 32'sd10);
		send_number(KIND_BIN, 32'sd1);
		send_number(KIND_HEX, 32'sd15);
		send_number(KIND_HEX, 32'sd16);
		send_number(KIND_HEX, 32'h7abc_def0);
		send_number(KIND_HEX, -32'sh0123_4567);
		send_number(KIND_DEC, 32'sd1_000_000_000);
	endtask

	// The receiver stops for a long stretch while numbers keep coming, so
	// the block fills and has to hold its input off.
	task automatic test_output_backpressure();
		send_idle_en = 1'b0;
		hold_req     = 1'b1;
		repeat (8) send_number(random_kind(), random_value());
		send_idle_en = 1'b1;
	endtask

	// The sender goes quiet until the block has delivered everything, then
	// resumes, so a number also arrives at a fully idle block.
	task automatic test_idle_restart();
		repeat (4) send_number(random_kind(), random_value());
		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_drain();
		repeat (5) send_number(random_kind(), random_value());
	endtask

	// Bulk random traffic with stalls on both sides.
	task automatic test_random_mix();
		repeat (RANDOM_ITEMS) send_number(random_kind(), random_value());
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		repeat (CLEAN_ITEMS) send_number(random_kind(), random_value());
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_DEC;
		value        = 32'sd0;
		error_count  = 0;
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		hold_req     = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_output_backpressure();
		test_idle_restart();
		test_random_mix();
		test_full_rate();

		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_drain();
		// Give a stray extra character time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_ctrl.sv
rtl/i2a_dp.sv
rtl/integer_to_ascii_radix_formatter.sv
test/integer_to_ascii_radix_formatter_tb.sv
